// ===== src/ssd_pkg.sv =====
// Shared constants and widths for the sigma spike detector.
// Used by the multiplier and the top-level sequencer; no dependencies.
`default_nettype none
package ssd_pkg;
   localparam int MAX_SAMPLES = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int EDGE_REACH  = 100;

   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
   localparam int SQ_W   = 2 * SAMPLE_BITS + ADDR_W;
   localparam int NX_W   = CNT_W + SAMPLE_BITS;
   localparam int DD_W   = 2 * NX_W;
   localparam int V_W    = CNT_W + SQ_W;
   localparam int CSR_W  = 8;
   localparam int KV_W   = CSR_W + V_W;
   localparam int H_W    = $clog2(EDGE_REACH + 1);
   localparam int MUL_W  = 32;

   // Operand splits so that every product fits the shared multiplier.
   localparam int Q_HALF = (SQ_W + 1) / 2;
   localparam int V_LO   = (V_W + 1) / 2;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_SIGMA_SQ = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_SIGMA_SQ = 1'd1;
   localparam logic [CSR_W-1:0] PEAK_SIGMA_SQ_RESET = 8'd25;
   localparam logic [CSR_W-1:0] EDGE_SIGMA_SQ_RESET = 8'd1;
endpackage
`default_nettype wire

// ===== src/ssd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the sample store of the spike detector.
`default_nettype none
module ssd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== src/ssd_mul.sv =====
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on ssd_pkg for the operand width.
`default_nettype none
module ssd_mul
   import ssd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [MUL_W-1:0]   a,
   input  wire logic [MUL_W-1:0]   b,
   output logic      [2*MUL_W-1:0] prod_ff
);
   logic [2*MUL_W-1:0] prod_in;

   assign prod_in = (2*MUL_W)'(a) * (2*MUL_W)'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

// ===== src/sigma_spike_detector.sv =====
// Sigma spike detector: a load request stores one sample and then folds its
// square into the running sum of squares in states LD1 and LD2. A find request
// on a complete sample set first forms the variance term n*Q - S*S and its two
// threshold products in states P0 to P8, then scans from the cursor; every
// sample test reads the store and passes twice through the one shared 32x32
// multiplier in states T0 to T4, between a state that issues it and one that
// acts on its outcome. Several samples may be tested per index because of the
// edge walks, and the result waits in an output register until taken.
// Depends on ssd_pkg, ssd_ram and ssd_mul.
`default_nettype none
module sigma_spike_detector
   import ssd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_kind,
   input  wire logic [15:0]            req_sample,
   input  wire logic                   req_last,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_found,
   output logic      [11:0]            rsp_peak_index,
   output logic      [15:0]            rsp_peak_value,
   output logic      [11:0]            rsp_start_index,
   output logic      [12:0]            rsp_end_index,
   input  wire logic                   csr_write,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_W-1:0]       csr_wdata
);
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_LD1   = 5'd1;
   localparam logic [4:0] ST_LD2   = 5'd2;
   localparam logic [4:0] ST_P0    = 5'd3;
   localparam logic [4:0] ST_P1    = 5'd4;
   localparam logic [4:0] ST_P2    = 5'd5;
   localparam logic [4:0] ST_P3    = 5'd6;
   localparam logic [4:0] ST_P4    = 5'd7;
   localparam logic [4:0] ST_P5    = 5'd8;
   localparam logic [4:0] ST_P6    = 5'd9;
   localparam logic [4:0] ST_P7    = 5'd10;
   localparam logic [4:0] ST_P8    = 5'd11;
   localparam logic [4:0] ST_SCAN  = 5'd12;
   localparam logic [4:0] ST_CHKP  = 5'd13;
   localparam logic [4:0] ST_LW    = 5'd14;
   localparam logic [4:0] ST_LWCHK = 5'd15;
   localparam logic [4:0] ST_RW    = 5'd16;
   localparam logic [4:0] ST_RWCHK = 5'd17;
   localparam logic [4:0] ST_SW    = 5'd18;
   localparam logic [4:0] ST_SWCHK = 5'd19;
   localparam logic [4:0] ST_EW    = 5'd20;
   localparam logic [4:0] ST_EWCHK = 5'd21;
   localparam logic [4:0] ST_DONE  = 5'd22;
   localparam logic [4:0] ST_T0    = 5'd23;
   localparam logic [4:0] ST_T1    = 5'd24;
   localparam logic [4:0] ST_T2    = 5'd25;
   localparam logic [4:0] ST_T3    = 5'd26;
   localparam logic [4:0] ST_T4    = 5'd27;
   localparam logic [4:0] ST_OUT   = 5'd28;

   localparam logic [H_W-1:0] H_REACH = H_W'(EDGE_REACH);

   logic [4:0]             state_ff, state_in, ret_ff, ret_in;
   logic [CNT_W-1:0]       count_ff, count_in, cursor_ff, cursor_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic                   complete_ff, complete_in;
   logic                   ld_add_ff, ld_add_in;
   logic [CSR_W-1:0]       peak_sq_ff, edge_sq_ff;
   logic [V_W-1:0]         v_ff, v_in;
   logic [KV_W-1:0]        kvp_ff, kvp_in, kve_ff, kve_in;
   logic [CNT_W-1:0]       i_ff, i_in, j_ff, j_in, end_ff, end_in;
   logic [ADDR_W-1:0]      start_ff, start_in;
   logic [H_W-1:0]         h_ff, h_in;
   logic [SAMPLE_BITS-1:0] x_ff, x_in, val_ff, val_in;
   logic [ADDR_W-1:0]      tst_addr_ff, tst_addr_in;
   logic                   tst_edge_ff, tst_edge_in;
   logic                   ok_ff, ok_in;
   logic                   neg_ff, neg_in;
   logic [NX_W-1:0]        d_ff, d_in;
   logic                   found_ff, found_in;
   logic [11:0]            rpi_ff, rpi_in, rsi_ff, rsi_in;
   logic [15:0]            rpv_ff, rpv_in;
   logic [12:0]            rei_ff, rei_in;

   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr;
   logic [SAMPLE_BITS-1:0] ram_q;
   logic [MUL_W-1:0]       mul_a, mul_b;
   logic [2*MUL_W-1:0]     prod;

   ssd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_store (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (req_sample),
      .raddr    (tst_addr_ff),
      .rdata_ff (ram_q)
   );

   ssd_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_found       = found_ff;
   assign rsp_peak_index  = rpi_ff;
   assign rsp_peak_value  = rpv_ff;
   assign rsp_start_index = rsi_ff;
   assign rsp_end_index   = rei_ff;

   always_comb begin
      logic [CNT_W-1:0] cnt_v;
      logic [SUM_W-1:0] sum_v;
      logic [NX_W-1:0]  nx_v;
      logic [CNT_W-1:0] ih_v;

      state_in    = state_ff;
      ret_in      = ret_ff;
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      sum_in      = sum_ff;
      sq_in       = sq_ff;
      complete_in = complete_ff;
      ld_add_in   = ld_add_ff;
      v_in        = v_ff;
      kvp_in      = kvp_ff;
      kve_in      = kve_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      h_in        = h_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      x_in        = x_ff;
      val_in      = val_ff;
      tst_addr_in = tst_addr_ff;
      tst_edge_in = tst_edge_ff;
      ok_in       = ok_ff;
      neg_in      = neg_ff;
      d_in        = d_ff;
      found_in    = found_ff;
      rpi_in      = rpi_ff;
      rpv_in      = rpv_ff;
      rsi_in      = rsi_ff;
      rei_in      = rei_ff;
      ram_we      = 1'b0;
      ram_waddr   = count_ff[ADDR_W-1:0];
      mul_a       = '0;
      mul_b       = '0;
      cnt_v       = complete_ff ? '0 : count_ff;
      sum_v       = complete_ff ? '0 : sum_ff;
      nx_v        = prod[NX_W-1:0];
      ih_v        = i_ff + CNT_W'(h_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_kind) begin
                  if (complete_ff) begin
                     complete_in = 1'b0;
                     cursor_in   = '0;
                     sq_in       = '0;
                  end
                  count_in  = cnt_v;
                  sum_in    = sum_v;
                  ld_add_in = 1'b0;
                  ram_waddr = cnt_v[ADDR_W-1:0];
                  // A sample beyond the store's depth is dropped.
                  if (cnt_v < CNT_W'(MAX_SAMPLES)) begin
                     ram_we    = 1'b1;
                     count_in  = cnt_v + 1'b1;
                     sum_in    = sum_v + SUM_W'(req_sample);
                     ld_add_in = 1'b1;
                  end
                  if (req_last) begin
                     complete_in = 1'b1;
                     cursor_in   = '0;
                  end
                  x_in     = req_sample;
                  state_in = ST_LD1;
               end else begin
                  found_in = 1'b0;
                  rpi_in   = '0;
                  rpv_in   = '0;
                  rsi_in   = '0;
                  rei_in   = '0;
                  if (complete_ff) begin
                     i_in     = cursor_ff;
                     state_in = ST_P0;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_LD1: begin
            mul_a    = MUL_W'(x_ff);
            mul_b    = MUL_W'(x_ff);
            state_in = ST_LD2;
         end
         ST_LD2: begin
            if (ld_add_ff) begin
               sq_in = sq_ff + SQ_W'(prod[2*SAMPLE_BITS-1:0]);
            end
            state_in = ST_IDLE;
         end
         ST_P0: begin
            mul_a    = MUL_W'(count_ff);
            mul_b    = MUL_W'(sq_ff[Q_HALF-1:0]);
            state_in = ST_P1;
         end
         ST_P1: begin
            v_in     = V_W'(prod[CNT_W+Q_HALF-1:0]);
            mul_a    = MUL_W'(count_ff);
            mul_b    = MUL_W'(sq_ff[SQ_W-1:Q_HALF]);
            state_in = ST_P2;
         end
         ST_P2: begin
            v_in     = v_ff + V_W'({prod[CNT_W+SQ_W-Q_HALF-1:0], {Q_HALF{1'b0}}});
            mul_a    = MUL_W'(sum_ff);
            mul_b    = MUL_W'(sum_ff);
            state_in = ST_P3;
         end
         ST_P3: begin
            v_in     = v_ff - V_W'(prod[2*SUM_W-1:0]);
            state_in = ST_P4;
         end
         ST_P4: begin
            mul_a    = MUL_W'(peak_sq_ff);
            mul_b    = MUL_W'(v_ff[V_LO-1:0]);
            state_in = ST_P5;
         end
         ST_P5: begin
            kvp_in   = KV_W'(prod[CSR_W+V_LO-1:0]);
            mul_a    = MUL_W'(peak_sq_ff);
            mul_b    = MUL_W'(v_ff[V_W-1:V_LO]);
            state_in = ST_P6;
         end
         ST_P6: begin
            kvp_in   = kvp_ff + KV_W'({prod[CSR_W+V_W-V_LO-1:0], {V_LO{1'b0}}});
            mul_a    = MUL_W'(edge_sq_ff);
            mul_b    = MUL_W'(v_ff[V_LO-1:0]);
            state_in = ST_P7;
         end
         ST_P7: begin
            kve_in   = KV_W'(prod[CSR_W+V_LO-1:0]);
            mul_a    = MUL_W'(edge_sq_ff);
            mul_b    = MUL_W'(v_ff[V_W-1:V_LO]);
            state_in = ST_P8;
         end
         ST_P8: begin
            kve_in   = kve_ff + KV_W'({prod[CSR_W+V_W-V_LO-1:0], {V_LO{1'b0}}});
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if ((i_ff + 1'b1) < count_ff) begin
               tst_addr_in = i_ff[ADDR_W-1:0];
               tst_edge_in = 1'b0;
               ret_in      = ST_CHKP;
               state_in    = ST_T0;
            end else begin
               cursor_in = count_ff;
               state_in  = ST_OUT;
            end
         end
         ST_CHKP: begin
            x_in = val_ff;
            if (!ok_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN;
            end else if (i_ff == '0) begin
               j_in     = i_ff + 1'b1;
               state_in = ST_RW;
            end else begin
               // The first step of the left walk also checks the left neighbor.
               j_in     = i_ff - 1'b1;
               state_in = ST_LW;
            end
         end
         ST_LW: begin
            tst_addr_in = j_ff[ADDR_W-1:0];
            tst_edge_in = 1'b1;
            ret_in      = ST_LWCHK;
            state_in    = ST_T0;
         end
         ST_LWCHK: begin
            if (!(x_ff > val_ff)) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN;
            end else if (!ok_ff) begin
               j_in     = i_ff + 1'b1;
               state_in = ST_RW;
            end else if (j_ff == '0) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN;
            end else begin
               j_in     = j_ff - 1'b1;
               state_in = ST_LW;
            end
         end
         ST_RW: begin
            if (j_ff >= count_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN;
            end else begin
               tst_addr_in = j_ff[ADDR_W-1:0];
               tst_edge_in = 1'b1;
               ret_in      = ST_RWCHK;
               state_in    = ST_T0;
            end
         end
         ST_RWCHK: begin
            if (!(x_ff > val_ff)) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN;
            end else if (!ok_ff) begin
               h_in = '0;
               if (i_ff == '0) begin
                  start_in = '0;
                  state_in = ST_EW;
               end else begin
                  state_in = ST_SW;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_RW;
            end
         end
         ST_SW: begin
            if (h_ff >= H_REACH) begin
               start_in = i_ff[ADDR_W-1:0];
               h_in     = H_W'(1);
               state_in = ST_EW;
            end else if (CNT_W'(h_ff) >= i_ff) begin
               start_in = '0;
               h_in     = H_W'(1);
               state_in = ST_EW;
            end else begin
               tst_addr_in = ADDR_W'(i_ff - CNT_W'(h_ff));
               tst_edge_in = 1'b1;
               ret_in      = ST_SWCHK;
               state_in    = ST_T0;
            end
         end
         ST_SWCHK: begin
            if (!ok_ff) begin
               start_in = ADDR_W'(i_ff - CNT_W'(h_ff));
               h_in     = H_W'(1);
               state_in = ST_EW;
            end else begin
               h_in     = h_ff + 1'b1;
               state_in = ST_SW;
            end
         end
         ST_EW: begin
            if (h_ff >= H_REACH) begin
               end_in   = i_ff;
               state_in = ST_DONE;
            end else if (ih_v >= count_ff) begin
               end_in   = ih_v;
               state_in = ST_DONE;
            end else begin
               tst_addr_in = ih_v[ADDR_W-1:0];
               tst_edge_in = 1'b1;
               ret_in      = ST_EWCHK;
               state_in    = ST_T0;
            end
         end
         ST_EWCHK: begin
            if (!ok_ff) begin
               end_in   = ih_v;
               state_in = ST_DONE;
            end else begin
               h_in     = h_ff + 1'b1;
               state_in = ST_EW;
            end
         end
         ST_DONE: begin
            cursor_in = i_ff + 1'b1;
            found_in  = 1'b1;
            rpi_in    = i_ff[11:0];
            rpv_in    = x_ff;
            rsi_in    = start_ff;
            rei_in    = end_ff;
            state_in  = ST_OUT;
         end
         // Sample test: read, n*x, deviation, square, compare with k*V.
         ST_T0: begin
            state_in = ST_T1;
         end
         ST_T1: begin
            val_in   = ram_q;
            mul_a    = MUL_W'(count_ff);
            mul_b    = MUL_W'(ram_q);
            state_in = ST_T2;
         end
         ST_T2: begin
            neg_in   = nx_v < NX_W'(sum_ff);
            d_in     = nx_v - NX_W'(sum_ff);
            state_in = ST_T3;
         end
         ST_T3: begin
            mul_a    = MUL_W'(d_ff);
            mul_b    = MUL_W'(d_ff);
            state_in = ST_T4;
         end
         ST_T4: begin
            ok_in    = !neg_ff &&
                       (KV_W'(prod[DD_W-1:0]) >= (tst_edge_ff ? kve_ff : kvp_ff));
            state_in = ret_ff;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         cursor_ff   <= '0;
         sum_ff      <= '0;
         sq_ff       <= '0;
         complete_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         cursor_ff   <= cursor_in;
         sum_ff      <= sum_in;
         sq_ff       <= sq_in;
         complete_ff <= complete_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_sq_ff <= PEAK_SIGMA_SQ_RESET;
         edge_sq_ff <= EDGE_SIGMA_SQ_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PEAK_SIGMA_SQ: peak_sq_ff <= csr_wdata;
            CSR_EDGE_SIGMA_SQ: edge_sq_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      ld_add_ff   <= ld_add_in;
      v_ff        <= v_in;
      kvp_ff      <= kvp_in;
      kve_ff      <= kve_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      h_ff        <= h_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      x_ff        <= x_in;
      val_ff      <= val_in;
      tst_addr_ff <= tst_addr_in;
      tst_edge_ff <= tst_edge_in;
      ok_ff       <= ok_in;
      neg_ff      <= neg_in;
      d_ff        <= d_in;
      found_ff    <= found_in;
      rpi_ff      <= rpi_in;
      rpv_ff      <= rpv_in;
      rsi_ff      <= rsi_in;
      rei_ff      <= rei_in;
   end
endmodule
`default_nettype wire
